// ===== src/i2c_master_peripheral_assert.svh =====
// Assertion macros for the I2C master peripheral.
// I2CM_ASSERT checks a property on every clock edge outside reset.
// I2CM_ASSERT_NEXT checks that a condition implies a result in the next cycle.
`ifndef I2C_MASTER_PERIPHERAL_ASSERT_SVH
`define I2C_MASTER_PERIPHERAL_ASSERT_SVH

`ifndef SYNTHESIS
`define I2CM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define I2CM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);
`else
`define I2CM_ASSERT(label, prop, msg)
`define I2CM_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== src/i2cm_pkg.sv =====
`default_nettype none

package i2cm_pkg;

    localparam int TIMER_BITS = 20;
    localparam int PER_W      = 16;
    localparam int NBITS_W    = 4;
    localparam int PROD_W     = PER_W + NBITS_W;
    localparam int SAT_W      = (TIMER_BITS > PROD_W) ? TIMER_BITS : PROD_W;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    // register indexes on the configuration port
    localparam logic [1:0] REG_FAST = 2'd0;
    localparam logic [1:0] REG_SLOW = 2'd1;
    localparam logic [1:0] REG_MASK = 2'd2;

    localparam logic [PER_W-1:0] FAST_RESET = 16'd20;
    localparam logic [PER_W-1:0] SLOW_RESET = 16'd80;

    // commands
    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_WDATA  = 3'd1;
    localparam logic [2:0] CMD_RDATA  = 3'd2;
    localparam logic [2:0] CMD_STATUS = 3'd3;
    localparam logic [2:0] CMD_CTRL   = 3'd4;

    // bus operations
    localparam logic [2:0] OP_NONE       = 3'd0;
    localparam logic [2:0] OP_START_WR   = 3'd1;
    localparam logic [2:0] OP_WRITE      = 3'd2;
    localparam logic [2:0] OP_READ_ACK   = 3'd3;
    localparam logic [2:0] OP_READ_NSTOP = 3'd4;
    localparam logic [2:0] OP_STOP       = 3'd5;

    // control register bits
    localparam int CTL_STOP_B   = 5;
    localparam int CTL_START_B  = 4;
    localparam int CTL_ENABLE_B = 0;
    localparam logic [1:0] SPEED_400K = 2'b10;
    localparam logic [1:0] SPEED_100K = 2'b01;

    localparam logic [NBITS_W-1:0] BITS_START = 4'd10;
    localparam logic [NBITS_W-1:0] BITS_DATA  = 4'd9;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_WRITE = 2'd1,
        PH_RADDR = 2'd2,
        PH_READ  = 2'd3
    } t_phase;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] write_byte;
        logic       slave_ack;
        logic [7:0] slave_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_byte;
        logic [2:0] bus_op;
        logic [7:0] bus_byte;
        logic       irq;
        logic       error;
    } t_out_item;

endpackage

`default_nettype wire

// ===== src/i2c_master_peripheral.sv =====
// Byte-level I2C master peripheral, one item per clock unless the output register stalls.
// Each accepted input transfer writes its result into the output register.
// One item per cycle; the output register stalls input only while full
// and not taken. The byte timer is loaded by one 16x4 multiply in the same cycle.
// Reset (synchronous, active low): idle phase, buffers empty, control and status
// clear, bit periods 20 and 80, interrupt unmasked, output register empty.
`default_nettype none

`include "i2c_master_peripheral_assert.svh"

module i2c_master_peripheral import i2cm_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output      logic                  o_in_ready,
    input  wire t_in_item              i_in_item,
    output      logic                  o_out_valid,
    input  wire logic                  i_out_ready,
    output      t_out_item             o_out_item,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output      logic [CFG_DATA_W-1:0] prdata,
    output      logic                  pready
);

    logic [PER_W-1:0]      r_fast_bits;
    logic [PER_W-1:0]      r_slow_bits;
    logic                  r_irq_mask;
    logic [TIMER_BITS-1:0] r_busy_timer, n_busy_timer;
    t_phase                r_phase, n_phase;
    logic                  r_pending_ack, n_pending_ack;
    logic [7:0]            r_tx_byte, n_tx_byte;
    logic                  r_tx_full, n_tx_full;
    logic [7:0]            r_rx_byte, n_rx_byte;
    logic                  r_rx_full, n_rx_full;
    logic [7:0]            r_ctrl, n_ctrl;
    logic                  r_ackn, n_ackn;
    logic                  r_ready, n_ready;
    logic                  r_out_valid;
    t_out_item             r_out_item, n_out_item;

    logic                  accept;
    logic                  cfg_wr;
    logic                  is_tick;
    logic                  timer_nz;
    logic                  timer_done;
    logic                  read_done;
    logic                  read_stop;
    logic                  start_cond;
    logic                  start_go;
    logic                  write_go;
    logic                  stop_go;
    logic                  raddr_go;
    logic                  load;
    logic [NBITS_W-1:0]    nbits;
    logic [PER_W-1:0]      per;
    logic                  bad_speed;
    logic [PROD_W-1:0]     prod;
    logic [SAT_W-1:0]      prod_ext;
    logic [TIMER_BITS-1:0] timer_load;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (paddr[3:2])
            REG_FAST: prdata = CFG_DATA_W'(r_fast_bits);
            REG_SLOW: prdata = CFG_DATA_W'(r_slow_bits);
            REG_MASK: prdata = CFG_DATA_W'(r_irq_mask);
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_bits <= FAST_RESET;
            r_slow_bits <= SLOW_RESET;
            r_irq_mask  <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_FAST: r_fast_bits <= pwdata[PER_W-1:0];
                REG_SLOW: r_slow_bits <= pwdata[PER_W-1:0];
                REG_MASK: r_irq_mask  <= pwdata[0];
                default:  ;
            endcase
        end
    end

    // tick decode
    assign is_tick    = accept && (i_in_item.cmd == CMD_TICK);
    assign timer_nz   = (r_busy_timer != '0);
    assign timer_done = is_tick && (r_busy_timer == TIMER_BITS'(1));
    assign read_done  = timer_done && (r_phase == PH_READ);
    assign read_stop  = read_done && r_ctrl[CTL_STOP_B];
    assign start_cond = ((r_phase == PH_IDLE) && r_tx_full) || r_ctrl[CTL_START_B];
    assign start_go   = is_tick && !timer_nz && start_cond && r_tx_full;
    assign write_go   = is_tick && !timer_nz && !start_cond && (r_phase == PH_WRITE)
                        && r_tx_full;
    assign stop_go    = is_tick && !timer_nz && !start_cond && (r_phase == PH_WRITE)
                        && !r_tx_full && r_ctrl[CTL_STOP_B];
    assign raddr_go   = is_tick && !timer_nz && !start_cond && (r_phase == PH_RADDR);
    assign load       = start_go || write_go || raddr_go || (read_done && !read_stop);
    assign nbits      = start_go ? BITS_START : BITS_DATA;

    // byte time: bit period (zero taken as one) times bit count, saturated to the timer width
    always_comb begin
        bad_speed = 1'b0;
        case (r_ctrl[3:2])
            SPEED_400K: per = r_fast_bits;
            SPEED_100K: per = r_slow_bits;
            default: begin
                per       = r_fast_bits;
                bad_speed = 1'b1;
            end
        endcase
        if (per == '0) begin
            per = PER_W'(1);
        end
        prod     = PROD_W'(per) * PROD_W'(nbits);
        prod_ext = SAT_W'(prod);
        if (prod_ext > SAT_W'({TIMER_BITS{1'b1}})) begin
            timer_load = {TIMER_BITS{1'b1}};
        end else begin
            timer_load = prod_ext[TIMER_BITS-1:0];
        end
    end

    // phase next state
    always_comb begin
        n_phase = r_phase;
        if (start_go) begin
            n_phase = r_tx_byte[0] ? PH_RADDR : PH_WRITE;
        end else if (stop_go || read_stop) begin
            n_phase = PH_IDLE;
        end else if (raddr_go) begin
            n_phase = PH_READ;
        end
    end

    // datapath and result
    always_comb begin
        n_busy_timer  = r_busy_timer;
        n_pending_ack = r_pending_ack;
        n_tx_byte     = r_tx_byte;
        n_tx_full     = r_tx_full;
        n_rx_byte     = r_rx_byte;
        n_rx_full     = r_rx_full;
        n_ctrl        = r_ctrl;
        n_ackn        = r_ackn;
        n_ready       = r_ready;
        n_out_item    = '0;

        if (load) begin
            n_busy_timer = bad_speed ? '0 : timer_load;
            if (bad_speed) begin
                n_out_item.error = 1'b1;
            end
        end else if (is_tick && timer_nz) begin
            n_busy_timer = r_busy_timer - TIMER_BITS'(1);
        end

        if (timer_done) begin
            n_ackn  = !r_pending_ack;
            n_ready = 1'b1;
        end

        if (read_done) begin
            if (r_rx_full) begin
                n_out_item.error = 1'b1;
            end
            n_rx_byte = i_in_item.slave_byte;
            n_rx_full = 1'b1;
            n_out_item.bus_op = read_stop ? OP_READ_NSTOP : OP_READ_ACK;
        end

        if (start_go || write_go) begin
            n_out_item.bus_op   = start_go ? OP_START_WR : OP_WRITE;
            n_out_item.bus_byte = r_tx_byte;
            n_pending_ack       = i_in_item.slave_ack;
            n_tx_full           = 1'b0;
        end
        if (start_go) begin
            n_ctrl[CTL_START_B] = 1'b0;
        end
        if (stop_go) begin
            n_out_item.bus_op = OP_STOP;
        end
        if (stop_go || read_stop) begin
            n_ctrl[CTL_STOP_B] = 1'b0;
        end

        if (accept) begin
            case (i_in_item.cmd)
                CMD_WDATA: begin
                    if (r_tx_full) begin
                        n_out_item.error = 1'b1;
                    end else begin
                        n_tx_byte = i_in_item.write_byte;
                        n_tx_full = 1'b1;
                    end
                end
                CMD_RDATA: begin
                    if (!r_rx_full) begin
                        n_out_item.error = 1'b1;
                    end
                    n_rx_full = 1'b0;
                    n_out_item.read_byte = r_rx_byte;
                end
                CMD_STATUS: begin
                    n_out_item.read_byte = {2'b00, r_irq_mask, 3'b000, r_ackn, r_ready};
                    n_ready = 1'b0;
                end
                CMD_CTRL: begin
                    n_ctrl = i_in_item.write_byte;
                end
                default: ;
            endcase
        end

        n_out_item.irq = n_ctrl[CTL_ENABLE_B] && n_ready && !r_irq_mask;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy_timer  <= '0;
            r_phase       <= PH_IDLE;
            r_pending_ack <= 1'b0;
            r_tx_byte     <= '0;
            r_tx_full     <= 1'b0;
            r_rx_byte     <= '0;
            r_rx_full     <= 1'b0;
            r_ctrl        <= '0;
            r_ackn        <= 1'b0;
            r_ready       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_busy_timer  <= n_busy_timer;
            r_phase       <= n_phase;
            r_pending_ack <= n_pending_ack;
            r_tx_byte     <= n_tx_byte;
            r_tx_full     <= n_tx_full;
            r_rx_byte     <= n_rx_byte;
            r_rx_full     <= n_rx_full;
            r_ctrl        <= n_ctrl;
            r_ackn        <= n_ackn;
            r_ready       <= n_ready;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_item <= n_out_item;
        end
    end

    `I2CM_ASSERT(a_timer_not_idle, (r_busy_timer == '0) || (r_phase != PH_IDLE), "byte timer running while idle")
    `I2CM_ASSERT_NEXT(a_start_drains_tx, start_go, !r_tx_full, "transmit buffer still full after start")
    `I2CM_ASSERT_NEXT(a_accept_result, accept, r_out_valid, "transfer accepted without result")

endmodule

`default_nettype wire
